@@ design/albi_pkg.sv @@
// Shared types, command and pattern codes, and helpers for the alarm indicator.
`timescale 1ns / 1ps

package albi_pkg;

    localparam int CNT_W = 17;
    localparam int PHASE_W = 16;
    localparam int HB_W = 7;

    localparam logic [2:0] CMD_TICK        = 3'd0;
    localparam logic [2:0] CMD_LEVELS      = 3'd1;
    localparam logic [2:0] CMD_SILENCE     = 3'd2;
    localparam logic [2:0] CMD_CLR_SILENCE = 3'd3;
    localparam logic [2:0] CMD_TEST        = 3'd4;
    localparam logic [2:0] CMD_PREJOIN     = 3'd5;
    localparam logic [2:0] CMD_STOP_PREJ   = 3'd6;
    localparam logic [2:0] CMD_JOIN_OK     = 3'd7;

    localparam logic [2:0] PAT_OFF       = 3'd0;
    localparam logic [2:0] PAT_FIRE      = 3'd1;
    localparam logic [2:0] PAT_ONOFF     = 3'd2;
    localparam logic [2:0] PAT_BEEP_BEEP = 3'd3;
    localparam logic [2:0] PAT_FAULT     = 3'd4;
    localparam logic [2:0] PAT_LOW_BATT  = 3'd5;

    localparam logic [HB_W-1:0]    HEARTBEAT_PERIOD = 7'd120;
    localparam logic [PHASE_W-1:0] LOWBATT_PERIOD   = 16'd16;
    localparam logic [PHASE_W-1:0] OFFLINE_PERIOD   = 16'd4;
    localparam logic [PHASE_W-1:0] SLOW_PERIOD      = 16'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] seconds;
        logic        local_alarm;
        logic        remote_alarm;
        logic        offline;
        logic        low_battery;
        logic        fault;
        logic        joining;
    } item_t;

    typedef struct packed {
        logic [2:0] buzzer_pattern;
        logic       buzzer_on;
        logic       red_led;
        logic       green_led;
    } result_t;

    typedef struct packed {
        logic               local_flag;
        logic               remote_flag;
        logic               offline_flag;
        logic               low_batt_flag;
        logic               fault_flag;
        logic               join_flag;
        logic [CNT_W-1:0]   silence_left;
        logic [CNT_W-1:0]   test_left;
        logic [CNT_W-1:0]   prejoin_left;
        logic [CNT_W-1:0]   join_ok_left;
        logic [HB_W-1:0]    heartbeat_phase;
        logic [PHASE_W-1:0] status_phase;
        logic               alarm_phase;
        logic               red_level;
        logic               green_level;
    } state_t;

    function automatic logic [PHASE_W-1:0] slow_step(input logic [PHASE_W-1:0] p,
                                                     input logic [PHASE_W-1:0] period);
        logic [PHASE_W-1:0] q;
        q = p + PHASE_W'(1);
        return (q >= period) ? '0 : q;
    endfunction

    function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] c);
        return (c != '0) ? c - CNT_W'(1) : c;
    endfunction

endpackage

@@ design/albi_step.sv @@
// Next-state and result logic for one accepted item.
`timescale 1ns / 1ps

module albi_step
    import albi_pkg::*;
(
    input  state_t  cur,
    input  item_t   item,
    output state_t  nxt,
    output result_t res
);

    logic [CNT_W-1:0] dur;
    logic             dur_ok;
    logic [2:0]       pat;

    assign dur    = {item.seconds, 1'b0};
    assign dur_ok = (item.seconds != '0);

    always_comb
    begin
        nxt = cur;
        nxt.local_flag    = item.local_alarm;
        nxt.remote_flag   = item.remote_alarm;
        nxt.offline_flag  = item.offline;
        nxt.low_batt_flag = item.low_battery;
        nxt.fault_flag    = item.fault;
        nxt.join_flag     = item.joining;

        case (item.cmd)
            CMD_TICK:
            begin
                nxt.join_ok_left = count_down(cur.join_ok_left);
                nxt.silence_left = count_down(cur.silence_left);
                nxt.test_left    = count_down(cur.test_left);
                nxt.prejoin_left = count_down(cur.prejoin_left);
                nxt.heartbeat_phase = '0;
                if (nxt.local_flag || nxt.remote_flag)
                begin
                    nxt.alarm_phase  = ~cur.alarm_phase;
                    nxt.red_level    = ~cur.alarm_phase;
                    nxt.green_level  = nxt.remote_flag;
                    nxt.status_phase = '0;
                end
                else if (nxt.join_flag)
                begin
                    nxt.status_phase = cur.status_phase ^ PHASE_W'(1);
                    nxt.red_level    = 1'b0;
                    nxt.green_level  = (nxt.status_phase != '0);
                end
                else if (nxt.join_ok_left != '0)
                begin
                    nxt.status_phase = slow_step(cur.status_phase, SLOW_PERIOD);
                    nxt.red_level    = 1'b0;
                    nxt.green_level  = (nxt.status_phase == '0);
                end
                else if (nxt.prejoin_left != '0)
                begin
                    nxt.status_phase = cur.status_phase ^ PHASE_W'(1);
                    nxt.red_level    = (nxt.status_phase != '0);
                    nxt.green_level  = 1'b0;
                end
                else if (nxt.test_left != '0)
                begin
                    nxt.status_phase = slow_step(cur.status_phase, SLOW_PERIOD);
                    nxt.red_level    = (nxt.status_phase == '0);
                    nxt.green_level  = (nxt.status_phase == '0);
                end
                else if (nxt.fault_flag)
                begin
                    nxt.status_phase = cur.status_phase + PHASE_W'(1);
                    nxt.red_level    = nxt.status_phase[0];
                    nxt.green_level  = ~nxt.status_phase[0];
                end
                else if (nxt.low_batt_flag)
                begin
                    nxt.status_phase = slow_step(cur.status_phase, LOWBATT_PERIOD);
                    nxt.red_level    = (nxt.status_phase == '0);
                    nxt.green_level  = 1'b0;
                end
                else if (nxt.offline_flag)
                begin
                    nxt.status_phase = slow_step(cur.status_phase, OFFLINE_PERIOD);
                    nxt.red_level    = (nxt.status_phase == '0);
                    nxt.green_level  = 1'b0;
                end
                else
                begin
                    nxt.heartbeat_phase = cur.heartbeat_phase + HB_W'(1);
                    if (nxt.heartbeat_phase >= HEARTBEAT_PERIOD)
                    begin
                        nxt.heartbeat_phase = '0;
                    end
                    nxt.red_level    = 1'b0;
                    nxt.green_level  = (nxt.heartbeat_phase == '0);
                    nxt.status_phase = '0;
                end
            end
            CMD_SILENCE:
            begin
                if (dur_ok)
                begin
                    nxt.silence_left = dur;
                end
            end
            CMD_CLR_SILENCE: nxt.silence_left = '0;
            CMD_TEST:
            begin
                if (dur_ok)
                begin
                    nxt.test_left = dur;
                end
            end
            CMD_PREJOIN:
            begin
                if (dur_ok)
                begin
                    nxt.prejoin_left = dur;
                end
            end
            CMD_STOP_PREJ: nxt.prejoin_left = '0;
            CMD_JOIN_OK:
            begin
                if (dur_ok)
                begin
                    nxt.join_ok_left = dur;
                end
            end
            CMD_LEVELS: ;
            default: ;
        endcase
    end

    always_comb
    begin
        if (nxt.local_flag || nxt.remote_flag)
        begin
            if (!nxt.local_flag && nxt.silence_left != '0)
            begin
                pat = PAT_OFF;
            end
            else
            begin
                pat = PAT_FIRE;
            end
        end
        else if (nxt.prejoin_left != '0)
        begin
            pat = PAT_ONOFF;
        end
        else if (nxt.test_left != '0)
        begin
            pat = PAT_BEEP_BEEP;
        end
        else if (nxt.fault_flag)
        begin
            pat = PAT_FAULT;
        end
        else if (nxt.low_batt_flag)
        begin
            pat = PAT_LOW_BATT;
        end
        else
        begin
            pat = PAT_OFF;
        end
    end

    assign res.buzzer_pattern = pat;
    assign res.buzzer_on      = (pat != PAT_OFF);
    assign res.red_led        = nxt.red_level;
    assign res.green_led      = nxt.green_level;

endmodule

@@ design/alarm_led_buzzer_indicator_core.sv @@
// Top level of the alarm LED and buzzer indicator: input stage, state and result register.
//
//  channel | dir | beat contents
//  s_*     | in  | tuser: cmd; tdata: seconds, six condition levels
//  m_*     | out | tdata: buzzer_pattern, buzzer_on, red_led, green_led
//
// Each beat is held in the input register and then moves to the result register, where its
// result is offered; while the output does not stall, one beat is accepted per cycle.
// The state update between the two registers is combinational.
// Reset clears all indicator state, counters and phases, and empties both stages.
// A stalled output holds both stages; s_tready drops only when both are full.
`timescale 1ns / 1ps

module alarm_led_buzzer_indicator_core
    import albi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // seconds[15:0], local_alarm, remote_alarm, offline,
                                   // low_battery, fault, joining, zero pad[23:22]
    input  logic [2:0]  s_tuser,   // cmd[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // buzzer_pattern[2:0], buzzer_on, red_led, green_led,
                                   // zero pad[7:6]
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    logic    out_free;
    logic    advance;
    item_t   s_item;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign s_item.cmd          = s_tuser;
    assign s_item.seconds      = s_tdata[15:0];
    assign s_item.local_alarm  = s_tdata[16];
    assign s_item.remote_alarm = s_tdata[17];
    assign s_item.offline      = s_tdata[18];
    assign s_item.low_battery  = s_tdata[19];
    assign s_item.fault        = s_tdata[20];
    assign s_item.joining      = s_tdata[21];

    albi_step u_step (
        .cur  (state_reg),
        .item (in_item_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= s_item;
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.green_led, out_res_reg.red_led,
                       out_res_reg.buzzer_on, out_res_reg.buzzer_pattern};

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without a beat moving to the output");

    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a stage was free");

    a_pattern_range: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_res_reg.buzzer_pattern <= PAT_LOW_BATT))
        else $error("buzzer pattern code out of range");

    a_alarm_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_next.local_flag) |=> (out_res_reg.buzzer_pattern == PAT_FIRE))
        else $error("local alarm did not select the fire pattern");

endmodule

@@ bench/tb_alarm_led_buzzer_indicator_core.sv @@
// Self-checking bench for the alarm LED and buzzer indicator core, with its own state predictor.
`timescale 1ns / 1ps

module tb_alarm_led_buzzer_indicator_core;
    import albi_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    alarm_led_buzzer_indicator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predicted indicator state
    logic                lvl_local, lvl_remote, lvl_offline, lvl_lowbatt, lvl_fault, lvl_join;
    logic [CNT_W-1:0]    silence_cnt, test_cnt, prejoin_cnt, joinok_cnt;
    logic [HB_W-1:0]     hb_ph;
    logic [PHASE_W-1:0]  st_ph;
    logic                al_ph, red_q, green_q;

    result_t pending_indications[$];
    int      mismatches = 0;
    bit      no_idle = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [PHASE_W-1:0] wrap_phase(input logic [PHASE_W-1:0] p,
                                                      input logic [PHASE_W-1:0] period);
        logic [PHASE_W-1:0] q;
        q = p + PHASE_W'(1);
        return (q >= period) ? '0 : q;
    endfunction

    function automatic logic [CNT_W-1:0] dec_window(input logic [CNT_W-1:0] c);
        return (c != '0) ? c - CNT_W'(1) : c;
    endfunction

    function automatic void tick_indicator();
        joinok_cnt  = dec_window(joinok_cnt);
        silence_cnt = dec_window(silence_cnt);
        test_cnt    = dec_window(test_cnt);
        prejoin_cnt = dec_window(prejoin_cnt);
        if (lvl_local || lvl_remote) begin
            al_ph   = ~al_ph;
            red_q   = al_ph;
            green_q = lvl_remote;
            hb_ph   = '0;
            st_ph   = '0;
        end else if (lvl_join || joinok_cnt != '0 || prejoin_cnt != '0 || test_cnt != '0
                     || lvl_fault || lvl_lowbatt || lvl_offline) begin
            if (lvl_join) begin
                st_ph   = st_ph ^ 16'd1;
                red_q   = 1'b0;
                green_q = (st_ph != '0);
            end else if (joinok_cnt != '0) begin
                st_ph   = wrap_phase(st_ph, SLOW_PERIOD);
                red_q   = 1'b0;
                green_q = (st_ph == '0);
            end else if (prejoin_cnt != '0) begin
                st_ph   = st_ph ^ 16'd1;
                red_q   = (st_ph != '0);
                green_q = 1'b0;
            end else if (test_cnt != '0) begin
                st_ph   = wrap_phase(st_ph, SLOW_PERIOD);
                red_q   = (st_ph == '0);
                green_q = red_q;
            end else if (lvl_fault) begin
                st_ph   = st_ph + PHASE_W'(1);
                red_q   = st_ph[0];
                green_q = ~st_ph[0];
            end else if (lvl_lowbatt) begin
                st_ph   = wrap_phase(st_ph, LOWBATT_PERIOD);
                red_q   = (st_ph == '0);
                green_q = 1'b0;
            end else begin
                st_ph   = wrap_phase(st_ph, OFFLINE_PERIOD);
                red_q   = (st_ph == '0);
                green_q = 1'b0;
            end
            hb_ph = '0;
        end else begin
            hb_ph = hb_ph + HB_W'(1);
            if (hb_ph >= HEARTBEAT_PERIOD)
                hb_ph = '0;
            red_q   = 1'b0;
            green_q = (hb_ph == '0);
            st_ph   = '0;
        end
    endfunction

    function automatic result_t next_indication(input item_t it);
        result_t         r;
        logic [CNT_W-1:0] halves;
        halves      = {it.seconds, 1'b0};
        lvl_local   = it.local_alarm;
        lvl_remote  = it.remote_alarm;
        lvl_offline = it.offline;
        lvl_lowbatt = it.low_battery;
        lvl_fault   = it.fault;
        lvl_join    = it.joining;
        case (it.cmd)
            CMD_TICK:        tick_indicator();
            CMD_SILENCE:     if (halves != '0) silence_cnt = halves;
            CMD_CLR_SILENCE: silence_cnt = '0;
            CMD_TEST:        if (halves != '0) test_cnt = halves;
            CMD_PREJOIN:     if (halves != '0) prejoin_cnt = halves;
            CMD_STOP_PREJ:   prejoin_cnt = '0;
            CMD_JOIN_OK:     if (halves != '0) joinok_cnt = halves;
            default:         ;
        endcase
        if (lvl_local || lvl_remote)
            r.buzzer_pattern = (!lvl_local && silence_cnt != '0) ? PAT_OFF : PAT_FIRE;
        else if (prejoin_cnt != '0)
            r.buzzer_pattern = PAT_ONOFF;
        else if (test_cnt != '0)
            r.buzzer_pattern = PAT_BEEP_BEEP;
        else if (lvl_fault)
            r.buzzer_pattern = PAT_FAULT;
        else if (lvl_lowbatt)
            r.buzzer_pattern = PAT_LOW_BATT;
        else
            r.buzzer_pattern = PAT_OFF;
        r.buzzer_on = (r.buzzer_pattern != PAT_OFF);
        r.red_led   = red_q;
        r.green_led = green_q;
        return r;
    endfunction

    // lv: local, remote, offline, low_battery, fault, joining
    function automatic item_t beat_of(input logic [2:0] c, input logic [15:0] s,
                                      input logic [5:0] lv);
        item_t it;
        it.cmd          = c;
        it.seconds      = s;
        it.local_alarm  = lv[5];
        it.remote_alarm = lv[4];
        it.offline      = lv[3];
        it.low_battery  = lv[2];
        it.fault        = lv[1];
        it.joining      = lv[0];
        return it;
    endfunction

    task automatic send_beat(input item_t it);
        if (!no_idle && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {2'b00, it.joining, it.fault, it.low_battery, it.offline,
                     it.remote_alarm, it.local_alarm, it.seconds};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_indications.push_back(next_indication(it));
    endtask

    task automatic wait_all_indications();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_indications.size() != 0) @(posedge clk);
    endtask

    always @(posedge clk) begin : check_results
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.buzzer_pattern = m_tdata[2:0];
            got.buzzer_on      = m_tdata[3];
            got.red_led        = m_tdata[4];
            got.green_led      = m_tdata[5];
            if (pending_indications.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat pat=%0d on=%0b red=%0b green=%0b", $time,
                         got.buzzer_pattern, got.buzzer_on, got.red_led, got.green_led);
            end else begin
                want = pending_indications.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: expected pat=%0d on=%0b red=%0b green=%0b, got pat=%0d on=%0b red=%0b green=%0b",
                             $time, want.buzzer_pattern, want.buzzer_on, want.red_led,
                             want.green_led, got.buzzer_pattern, got.buzzer_on,
                             got.red_led, got.green_led);
                end
            end
        end
        m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 38);
    end

    task automatic test_directed();
        send_beat(beat_of(CMD_TICK,        16'd0,     6'b000000));
        send_beat(beat_of(CMD_LEVELS,      16'hFFFF,  6'b111111));
        send_beat(beat_of(CMD_TICK,        16'hFFFF,  6'b111111));
        send_beat(beat_of(CMD_SILENCE,     16'd0,     6'b010000));
        send_beat(beat_of(CMD_SILENCE,     16'hFFFF,  6'b010000));
        send_beat(beat_of(CMD_TICK,        16'd0,     6'b010000));
        send_beat(beat_of(CMD_TICK,        16'd0,     6'b110000));
        send_beat(beat_of(CMD_CLR_SILENCE, 16'd0,     6'b010000));
        send_beat(beat_of(CMD_CLR_SILENCE, 16'd0,     6'b010000));
        send_beat(beat_of(CMD_TEST,        16'd0,     6'b000000));
        send_beat(beat_of(CMD_TEST,        16'hFFFF,  6'b000000));
        send_beat(beat_of(CMD_TEST,        16'd1,     6'b000000));
        send_beat(beat_of(CMD_TICK,        16'd0,     6'b000110));
        send_beat(beat_of(CMD_PREJOIN,     16'd0,     6'b000000));
        send_beat(beat_of(CMD_PREJOIN,     16'd1,     6'b000000));
        send_beat(beat_of(CMD_TICK,        16'd0,     6'b000010));
        send_beat(beat_of(CMD_STOP_PREJ,   16'd0,     6'b000000));
        send_beat(beat_of(CMD_STOP_PREJ,   16'd0,     6'b000000));
        send_beat(beat_of(CMD_JOIN_OK,     16'd0,     6'b000000));
        send_beat(beat_of(CMD_JOIN_OK,     16'd2,     6'b000000));
        send_beat(beat_of(CMD_TICK,        16'd0,     6'b000001));
        send_beat(beat_of(CMD_TICK,        16'd0,     6'b000000));
        send_beat(beat_of(CMD_TICK,        16'd0,     6'b000010));
        send_beat(beat_of(CMD_TICK,        16'h5555,  6'b000100));
        send_beat(beat_of(CMD_TICK,        16'hAAAA,  6'b001000));
    endtask

    task automatic test_heartbeat_wrap();
        repeat (130) send_beat(beat_of(CMD_TICK, 16'd0, 6'b000000));
    endtask

    // run the fault phase up, then toggle from a large phase
    task automatic test_phase_wrap();
        no_idle = 1'b1;
        repeat (200) send_beat(beat_of(CMD_TICK, 16'd0, 6'b000010));
        repeat (3) send_beat(beat_of(CMD_TICK, 16'd0, 6'b000001));
        repeat (100) send_beat(beat_of(CMD_TICK, 16'd0, 6'b000010));
        send_beat(beat_of(CMD_PREJOIN, 16'd3, 6'b000010));
        repeat (8) send_beat(beat_of(CMD_TICK, 16'd0, 6'b000010));
        no_idle = 1'b0;
        wait_all_indications();
    endtask

    task automatic test_random(input int count);
        logic [5:0]  lv;
        logic [2:0]  c;
        logic [15:0] s;
        int          pick;
        lv = '0;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 6)
                for (int b = 0; b < 6; b++) lv[b] = ($urandom_range(99) < 25);
            pick = $urandom_range(99);
            if (pick < 55)       c = CMD_TICK;
            else if (pick < 62)  c = CMD_LEVELS;
            else if (pick < 68)  c = CMD_SILENCE;
            else if (pick < 74)  c = CMD_CLR_SILENCE;
            else if (pick < 81)  c = CMD_TEST;
            else if (pick < 88)  c = CMD_PREJOIN;
            else if (pick < 93)  c = CMD_STOP_PREJ;
            else                 c = CMD_JOIN_OK;
            pick = $urandom_range(99);
            if (pick < 70)       s = 16'($urandom_range(8, 1));
            else if (pick < 80)  s = '0;
            else                 s = 16'($urandom);
            send_beat(beat_of(c, s, lv));
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        lvl_local = 1'b0; lvl_remote = 1'b0; lvl_offline = 1'b0;
        lvl_lowbatt = 1'b0; lvl_fault = 1'b0; lvl_join = 1'b0;
        silence_cnt = '0; test_cnt = '0; prejoin_cnt = '0; joinok_cnt = '0;
        hb_ph = '0; st_ph = '0; al_ph = 1'b0; red_q = 1'b0; green_q = 1'b0;

        test_directed();
        test_heartbeat_wrap();
        test_phase_wrap();
        test_random(500);
        no_idle = 1'b1;
        test_random(350);
        no_idle = 1'b0;
        wait_all_indications();
        test_random(480);

        wait_all_indications();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
design/albi_pkg.sv
design/albi_step.sv
design/alarm_led_buzzer_indicator_core.sv
bench/tb_alarm_led_buzzer_indicator_core.sv
